### design/iira_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iira_pkg: shared definitions for the indexed insert/remove array
// Operation and status codes, fixed port widths and parameter defaults.
// ----------------------------------------------------------------------------
package iira_pkg;

    localparam int OP_W    = 3;
    localparam int INDEX_W = 5;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;
    localparam int WIDE_W  = 64;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_ELEM_WIDTH = 32;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam op_t OP_APPEND = 3'd0;
    localparam op_t OP_INSERT = 3'd1;
    localparam op_t OP_REMOVE = 3'd2;
    localparam op_t OP_READ   = 3'd3;
    localparam op_t OP_WRITE  = 3'd4;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_BAD_INDEX = 2'd2;

endpackage

### design/iira_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iira_mem: element store
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module iira_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/indexed_insert_remove_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_remove_array: fixed-capacity ordered array
// Append, insert, remove, read and write on a RAM-backed list with a count.
// ----------------------------------------------------------------------------
// Append, write, refused and unused operations complete directly from idle;
// read waits in S_RD_WAIT for the registered RAM data; remove shifts later
// entries down, insert shifts entries up and then writes the new one, unless
// it lands at the end. Shifts move one entry per cycle through the RAM.
// busy holds off the next item, which can go in at the edge that takes the
// result; done cannot be held off. Reset clears count and sequencer, not RAM.
module indexed_insert_remove_array
    import iira_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           op,
    input  logic [INDEX_W-1:0]        index,
    input  logic signed [DATA_W-1:0]  data_in,
    output logic                      done,
    output logic signed [DATA_W-1:0]  read_data,
    output logic [STAT_W-1:0]         status,
    output logic [COUNT_W-1:0]        count
);

    // Address width of the store, width of the element count, and the width
    // used when the 5-bit index is compared against the count.
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SHIFT_UP  = 3'd1;
    localparam logic [2:0] S_INS_FINAL = 3'd2;
    localparam logic [2:0] S_SHIFT_DN  = 3'd3;
    localparam logic [2:0] S_RD_WAIT   = 3'd4;

    logic [2:0]            state_reg,  state_next;
    logic [CNT_W-1:0]      count_reg,  count_next;
    logic                  done_reg,   done_next;
    logic [ADDR_W-1:0]     idx_reg,    idx_next;
    logic [ADDR_W-1:0]     ptr_reg,    ptr_next;
    logic [ELEM_WIDTH-1:0] val_reg,    val_next;
    logic [DATA_W-1:0]     rd_reg,     rd_next;
    status_t               status_reg, status_next;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [ELEM_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [ELEM_WIDTH-1:0] mem_rdata;

    logic                  accept;
    logic                  full;
    logic [CMP_W-1:0]      idx_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic [ADDR_W-1:0]     idx_addr;
    logic [ADDR_W-1:0]     cnt_addr;
    logic [CNT_W-1:0]      cnt_last;
    logic [ADDR_W-1:0]     last_addr;
    logic [WIDE_W-1:0]     din_wide;
    logic [WIDE_W-1:0]     rdata_wide;
    logic [ELEM_WIDTH-1:0] din_elem;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign idx_ext   = CMP_W'(index);
    assign cnt_ext   = CMP_W'(count_reg);
    assign idx_addr  = ADDR_W'(index);
    assign cnt_addr  = ADDR_W'(count_reg);
    assign cnt_last  = count_reg - CNT_W'(1);
    assign last_addr = ADDR_W'(cnt_last);

    // Elements keep the low ELEM_WIDTH bits of data_in; reads return the
    // element zero-extended and cut to the 32-bit result port.
    assign din_wide   = {{(WIDE_W - DATA_W){1'b0}}, data_in};
    assign din_elem   = din_wide[ELEM_WIDTH-1:0];
    assign rdata_wide = WIDE_W'(mem_rdata);

    iira_mem #(
        .DEPTH  (CAPACITY),
        .WIDTH  (ELEM_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Next-state logic. The shift loops are pipelined through the RAM: the
    // entry read at one edge is written back one place over at the next edge
    // while the following entry is read. The read and write addresses in a
    // shift cycle are always two apart, so no forwarding is needed.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        idx_next    = idx_reg;
        ptr_next    = ptr_reg;
        val_next    = val_reg;
        rd_next     = rd_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_addr;
        mem_wdata   = din_elem;
        mem_re      = 1'b0;
        mem_raddr   = idx_addr;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next    = idx_addr;
                    val_next    = din_elem;
                    rd_next     = '0;
                    status_next = ST_OK;
                    done_next   = 1'b1;
                    case (op)
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = cnt_addr;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (idx_ext > cnt_ext)
                            begin
                                status_next = ST_BAD_INDEX;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (idx_ext == cnt_ext)
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                // Start moving entries up from the top one.
                                done_next  = 1'b0;
                                mem_re     = 1'b1;
                                mem_raddr  = last_addr;
                                ptr_next   = last_addr;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (idx_ext >= cnt_ext)
                            begin
                                status_next = ST_BAD_INDEX;
                            end
                            else if (idx_addr == last_addr)
                            begin
                                count_next = cnt_last;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                mem_re     = 1'b1;
                                mem_raddr  = idx_addr + ADDR_W'(1);
                                ptr_next   = idx_addr + ADDR_W'(1);
                                state_next = S_SHIFT_DN;
                            end
                        end
                        OP_READ:
                        begin
                            if (idx_ext >= cnt_ext)
                            begin
                                status_next = ST_BAD_INDEX;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                mem_re     = 1'b1;
                                state_next = S_RD_WAIT;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (idx_ext >= cnt_ext)
                            begin
                                status_next = ST_BAD_INDEX;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                            end
                        end
                        default:
                        begin
                            // Unused codes complete with status ok and no change.
                        end
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg + ADDR_W'(1);
                mem_wdata = mem_rdata;
                if (ptr_reg == idx_reg)
                begin
                    state_next = S_INS_FINAL;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg - ADDR_W'(1);
                    ptr_next  = ptr_reg - ADDR_W'(1);
                end
            end
            S_INS_FINAL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SHIFT_DN:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg - ADDR_W'(1);
                mem_wdata = mem_rdata;
                if (ptr_reg == last_addr)
                begin
                    count_next = cnt_last;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + ADDR_W'(1);
                    ptr_next  = ptr_reg + ADDR_W'(1);
                end
            end
            S_RD_WAIT:
            begin
                rd_next    = rdata_wide[DATA_W-1:0];
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Operands and result payload.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        ptr_reg    <= ptr_next;
        val_reg    <= val_next;
        rd_reg     <= rd_next;
        status_reg <= status_next;
    end

    assign done      = done_reg;
    assign read_data = rd_reg;
    assign status    = status_reg;
    assign count     = COUNT_W'(count_reg);

    // The result strobe only appears once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while sequencer busy");

    // The element count never exceeds the capacity.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // An accepted read either completes at once or waits in S_RD_WAIT for the RAM data.
    a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_READ)) |=> (done_reg || (state_reg == S_RD_WAIT)))
        else $error("read did not follow the RAM read path");

    // The count only changes at the edge that raises the result strobe.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (done_reg || $past(accept)))
        else $error("count changed without completing an item");

endmodule
